@@ rtl/lzss_compressed_size_scanner_defines.svh @@
// ----------------------------------------------------------------------------
// LZSS compressed-size scanner assertion macros
// Shared concurrent assertion forms used by the scanner RTL.
// ----------------------------------------------------------------------------
`ifndef LZSS_COMPRESSED_SIZE_SCANNER_DEFINES_SVH
`define LZSS_COMPRESSED_SIZE_SCANNER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LZCS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LZCS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lzcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lzcs_pkg
// Types and constants shared by the LZSS compressed-size scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lzcs_pkg;

    localparam int SIZE_W      = 25;
    localparam int COUNT_W     = SIZE_W + 1;
    localparam int DLIM_W      = 24;
    localparam int S_TDATA_W   = 8;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 56;

    localparam logic [SIZE_W-1:0]  LIMIT_RESET  = 25'h1FFFFFF;
    localparam logic [COUNT_W-1:0] HEADER_BYTES = 26'd4;
    localparam logic [3:0]         FLAG_BITS    = 4'd8;
    localparam logic [SIZE_W-1:0]  MIN_MATCH    = 25'd3;
    localparam logic [1:0]         HDR_LAST     = 2'd3;

    typedef struct packed {
        logic       start_req;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [SIZE_W-1:0] decoded_total;
        logic [SIZE_W-1:0] compressed_size;
    } result_t;

endpackage

@@ rtl/lzcs_in_reg.sv @@
// ----------------------------------------------------------------------------
// lzcs_in_reg
// Input register stage; holds one byte transaction until the scan takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzcs_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  lzcs_pkg::in_item_t in_item,
    input  logic              advance,
    output logic              item_fire,
    output lzcs_pkg::in_item_t item
);
    import lzcs_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    assign in_ready  = !valid_reg || advance;
    assign item_fire = valid_reg && advance;
    assign item      = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

@@ rtl/lzcs_scan.sv @@
// ----------------------------------------------------------------------------
// lzcs_scan
// Scan state and per-byte step logic: header, flag bytes, items, end test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzcs_scan (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         item_fire,
    input  lzcs_pkg::in_item_t           item,
    input  logic [lzcs_pkg::SIZE_W-1:0]  buffer_limit,
    output logic                         res_valid,
    output lzcs_pkg::result_t            res
);
    import lzcs_pkg::*;
    `include "lzss_compressed_size_scanner_defines.svh"

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD,
        PH_FLAG,
        PH_ITEM,
        PH_SKIP
    } phase_t;

    phase_t              phase_reg,     phase_next;
    logic [1:0]          hdr_idx_reg,   hdr_idx_next;
    logic [DLIM_W-1:0]   dlim_reg,      dlim_next;
    logic [7:0]          flags_reg,     flags_next;
    logic [3:0]          bits_left_reg, bits_left_next;
    logic [COUNT_W-1:0]  bcount_reg,    bcount_next;
    logic [SIZE_W-1:0]   dcount_reg,    dcount_next;

    logic                test_end;
    logic                is_end;
    logic [COUNT_W-1:0]  rounded;
    logic [7:0]          b;

    assign b = item.data_byte;

    always_comb begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        dlim_next      = dlim_reg;
        flags_next     = flags_reg;
        bits_left_next = bits_left_reg;
        bcount_next    = bcount_reg;
        dcount_next    = dcount_reg;
        test_end       = 1'b0;

        if (item.start_req) begin
            phase_next     = PH_HEAD;
            hdr_idx_next   = 2'd1;
            dlim_next      = '0;
            flags_next     = '0;
            bits_left_next = '0;
            bcount_next    = '0;
            dcount_next    = '0;
        end else begin
            unique case (phase_reg)
                PH_HEAD: begin
                    case (hdr_idx_reg)
                        2'd1:    dlim_next = dlim_reg | {16'd0, b};
                        2'd2:    dlim_next = dlim_reg | {8'd0, b, 8'd0};
                        2'd3:    dlim_next = dlim_reg | {b, 16'd0};
                        default: dlim_next = dlim_reg;
                    endcase
                    if (hdr_idx_reg == HDR_LAST) begin
                        hdr_idx_next = 2'd0;
                        bcount_next  = HEADER_BYTES;
                        phase_next   = PH_FLAG;
                        test_end     = 1'b1;
                    end else begin
                        hdr_idx_next = hdr_idx_reg + 2'd1;
                    end
                end
                PH_FLAG: begin
                    flags_next     = b;
                    bits_left_next = FLAG_BITS;
                    bcount_next    = bcount_reg + 26'd1;
                    phase_next     = PH_ITEM;
                    test_end       = 1'b1;
                end
                PH_ITEM: begin
                    flags_next     = {flags_reg[6:0], 1'b0};
                    bits_left_next = bits_left_reg - 4'd1;
                    test_end       = 1'b1;
                    if (flags_reg[7]) begin
                        dcount_next = dcount_reg + {21'd0, b[7:4]} + MIN_MATCH;
                        bcount_next = bcount_reg + 26'd2;
                        phase_next  = PH_SKIP;
                    end else begin
                        dcount_next = dcount_reg + 25'd1;
                        bcount_next = bcount_reg + 26'd1;
                        phase_next  = (bits_left_next != 4'd0) ? PH_ITEM : PH_FLAG;
                    end
                end
                PH_SKIP: begin
                    phase_next = (bits_left_reg != 4'd0) ? PH_ITEM : PH_FLAG;
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end

        is_end = test_end &&
                 !((bcount_next < {1'b0, buffer_limit}) &&
                   (dcount_next < {1'b0, dlim_next}));
        if (is_end) begin
            phase_next = PH_IDLE;
        end
    end

    assign rounded = (bcount_next + 26'd3) & ~26'd3;

    always_comb begin
        res.decoded_total = dcount_next;
        if (rounded > {1'b0, buffer_limit}) begin
            res.compressed_size = buffer_limit;
        end else begin
            res.compressed_size = rounded[SIZE_W-1:0];
        end
    end

    assign res_valid = item_fire && is_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            hdr_idx_reg   <= '0;
            dlim_reg      <= '0;
            flags_reg     <= '0;
            bits_left_reg <= '0;
            bcount_reg    <= '0;
            dcount_reg    <= '0;
        end else if (item_fire) begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            dlim_reg      <= dlim_next;
            flags_reg     <= flags_next;
            bits_left_reg <= bits_left_next;
            bcount_reg    <= bcount_next;
            dcount_reg    <= dcount_next;
        end
    end

    `LZCS_ASSERT_NEXT(a_idle_after_result, aclk, aresetn, res_valid, phase_reg == PH_IDLE, "scan not idle after result")
    `LZCS_ASSERT_NEXT(a_start_clears, aclk, aresetn, item_fire && item.start_req, (phase_reg == PH_HEAD) && (bcount_reg == '0) && (dcount_reg == '0), "start did not restart scan")
    `LZCS_ASSERT_SAME(a_bcount_bound, aclk, aresetn, phase_reg != PH_IDLE, bcount_reg <= 26'h2000000, "byte count out of range")
    `LZCS_ASSERT_SAME(a_no_result_idle, aclk, aresetn, item_fire && !item.start_req && (phase_reg == PH_IDLE || phase_reg == PH_SKIP), !res_valid, "result from idle or skip byte")

endmodule

@@ rtl/lzcs_out_reg.sv @@
// ----------------------------------------------------------------------------
// lzcs_out_reg
// Result register; holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzcs_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  lzcs_pkg::result_t res,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_ready,
    output lzcs_pkg::result_t out_res
);
    import lzcs_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign advance   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_valid) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

endmodule

@@ rtl/lzss_compressed_size_scanner.sv @@
// ----------------------------------------------------------------------------
// lzss_compressed_size_scanner
// Scans a type-10 LZSS stream byte by byte and reports its compressed size.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_      | in  | tdata[7:0] data_byte, tuser[0] start_req
//  m_      | out | tdata[24:0] compressed_size, tdata[49:25] decoded_total
//  cfg_    | in  | data[24:0] buffer_limit
//
//  One byte per cycle while the m_ side is not stalled; results leave the result register.
//  The step logic runs between the input register and the result register.
//  Reset: synchronous, active low; buffer_limit returns to 0x1FFFFFF.
//  A stalled m_ side still lets one more byte into the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzss_compressed_size_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [24:0] compressed_size, [49:25] decoded_total
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [24:0] cfg_data
);
    import lzcs_pkg::*;

    logic [SIZE_W-1:0] limit_reg;
    in_item_t          s_item;
    in_item_t          item;
    logic              item_fire;
    logic              advance;
    logic              res_valid;
    result_t           res;
    result_t           out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    assign s_item.data_byte = s_tdata;
    assign s_item.start_req = s_tuser[0];

    lzcs_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .advance   (advance),
        .item_fire (item_fire),
        .item      (item)
    );

    lzcs_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_fire    (item_fire),
        .item         (item),
        .buffer_limit (limit_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    lzcs_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {6'd0, out_res.decoded_total, out_res.compressed_size};

endmodule
